// ----- rtl/csalu_pkg.sv -----
// ----------------------------------------------------------------------------
// csalu_pkg
// Shared types and codes of the complex stack calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package csalu_pkg;

  localparam logic [2:0] MODE_PUSH = 3'd0;
  localparam logic [2:0] MODE_POP  = 3'd1;
  localparam logic [2:0] MODE_ADD  = 3'd2;
  localparam logic [2:0] MODE_SUB  = 3'd3;
  localparam logic [2:0] MODE_MUL  = 3'd4;
  localparam logic [2:0] MODE_DIV  = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;

  localparam logic [2:0] MUL_AR_BR = 3'd0;
  localparam logic [2:0] MUL_AI_BI = 3'd1;
  localparam logic [2:0] MUL_AR_BI = 3'd2;
  localparam logic [2:0] MUL_AI_BR = 3'd3;
  localparam logic [2:0] MUL_BR_BR = 3'd4;
  localparam logic [2:0] MUL_BI_BI = 3'd5;

  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  localparam logic [3:0] RES_NONE   = 4'd0;
  localparam logic [3:0] RES_IN     = 4'd1;
  localparam logic [3:0] RES_MEM    = 4'd2;
  localparam logic [3:0] RES_ADD    = 4'd3;
  localparam logic [3:0] RES_SUB    = 4'd4;
  localparam logic [3:0] RES_MUL_RE = 4'd5;
  localparam logic [3:0] RES_MUL_IM = 4'd6;
  localparam logic [3:0] RES_DIV_RE = 4'd7;
  localparam logic [3:0] RES_DIV_IM = 4'd8;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] real_in;
    logic signed [31:0] imag_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic [2:0]         status;
    logic [6:0]         stack_depth;
  } out_item_t;

  typedef struct packed {
    logic       ld_in;
    logic       wr_en;
    logic       rd_en;
    logic       rd_sec;
    logic       ld_a;
    logic       ld_b;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic [1:0] acc_op;
    logic [1:0] den_op;
    logic       div_start;
    logic [3:0] res_op;
    logic       st_we;
    logic [2:0] st;
    logic       out_load;
  } csalu_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic cnt_lt2;
    logic full;
    logic b_zero;
    logic div_busy;
  } csalu_sts_t;

endpackage

`default_nettype wire

// ----- rtl/csalu_div.sv -----
// ----------------------------------------------------------------------------
// csalu_div
// Restoring divider: floor(num * 2^16 / den), one quotient bit a cycle,
// 2^32 when the quotient does not fit in 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module csalu_div import csalu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             busy,
  output logic [32:0]      quo
);

  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] sh_r, sh_nxt;
  logic [63:0] dv_r, dv_nxt;
  logic        ovf_r, ovf_nxt;
  logic [64:0] r2;
  logic [64:0] r2_sub;
  logic        ge;

  always_comb begin
    r2       = {rem_r, sh_r[31]};
    r2_sub   = r2 - {1'b0, dv_r};
    ge       = r2 >= {1'b0, dv_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    dv_nxt   = dv_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      ovf_nxt  = {16'd0, num} >= {den, 16'd0};
      busy_nxt = !({16'd0, num} >= {den, 16'd0});
      rem_nxt  = {16'd0, num[63:16]};
      sh_nxt   = {num[15:0], 16'd0};
      dv_nxt   = den;
      cnt_nxt  = 5'd0;
    end else if (busy_r) begin
      rem_nxt = ge ? r2_sub[63:0] : r2[63:0];
      sh_nxt  = {sh_r[30:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    dv_r  <= dv_nxt;
    ovf_r <= ovf_nxt;
  end

  assign busy = busy_r;
  assign quo  = ovf_r ? 33'h1_0000_0000 : {1'b0, sh_r};

endmodule

`default_nettype wire

// ----- rtl/csalu_dpath.sv -----
// ----------------------------------------------------------------------------
// csalu_dpath
// Stack memory, entry count, shared multiplier, accumulators, divider and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module csalu_dpath import csalu_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   in_data,
  input  wire csalu_cmd_t cmd,
  output csalu_sts_t      sts,
  output out_item_t       out_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [63:0] mem [STACK_DEPTH];
  logic [63:0] mem_q_r;

  in_item_t           in_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic signed [31:0] ar_r, ai_r, br_r, bi_r;
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r;
  logic [63:0]        den_r;
  logic               div_neg_r;
  logic signed [31:0] res_re_r, res_im_r;
  logic               sat_r;
  logic [2:0]         st_r;
  out_item_t          out_r;

  logic [CW-1:0]      cnt_m1, cnt_m2, rd_sel;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic signed [31:0] op_x, op_y;
  logic signed [65:0] acc_abs;
  logic [63:0]        acc_mag;
  logic               acc_neg;
  logic               div_busy;
  logic [32:0]        div_quo;
  logic [32:0]        add_c, sub_c, mre_c, mim_c, sim_c, dv_c;
  logic [CW+6:0]      depth_ext;

  function automatic logic [32:0] clamp_s33(input logic signed [32:0] s);
    logic [32:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    end else begin
      r = {1'b0, s[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] clamp_sm(input logic neg, input logic [47:0] mag);
    logic [32:0] r;
    if (!neg) begin
      if (|mag[47:31]) begin
        r = {1'b1, 32'h7FFF_FFFF};
      end else begin
        r = {1'b0, mag[31:0]};
      end
    end else if (mag > 48'h0000_8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else if (mag == 48'h0000_8000_0000) begin
      r = {1'b0, 32'h8000_0000};
    end else begin
      r = {1'b0, (~mag[31:0]) + 32'd1};
    end
    return r;
  endfunction

  assign cnt_m1  = cnt_r - CW'(1);
  assign cnt_m2  = cnt_r - CW'(2);
  assign rd_sel  = cmd.rd_sec ? cnt_m2 : cnt_m1;
  assign rd_addr = rd_sel[AW-1:0];
  assign wr_addr = cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= {in_r.real_in, in_r.imag_in};
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_m1;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_AR_BR: begin op_x = ar_r; op_y = br_r; end
      MUL_AI_BI: begin op_x = ai_r; op_y = bi_r; end
      MUL_AR_BI: begin op_x = ar_r; op_y = bi_r; end
      MUL_AI_BR: begin op_x = ai_r; op_y = br_r; end
      MUL_BR_BR: begin op_x = br_r; op_y = br_r; end
      MUL_BI_BI: begin op_x = bi_r; op_y = bi_r; end
      default:   begin op_x = ar_r; op_y = br_r; end
    endcase
  end

  assign acc_neg = acc_r[65];
  assign acc_abs = acc_neg ? -acc_r : acc_r;
  assign acc_mag = acc_abs[63:0];

  csalu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (acc_mag),
    .den   (den_r),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign add_c = clamp_s33(33'(ar_r) + 33'(br_r));
  assign sub_c = clamp_s33(33'(ar_r) - 33'(br_r));
  assign mre_c = clamp_sm(acc_neg, acc_mag[63:16]);
  assign mim_c = clamp_s33(33'(ai_r) + 33'(bi_r));
  assign sim_c = clamp_s33(33'(ai_r) - 33'(bi_r));
  assign dv_c  = clamp_sm(div_neg_r, {15'd0, div_quo});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (cmd.ld_in) begin
      in_r     <= in_data;
      res_re_r <= '0;
      res_im_r <= '0;
      sat_r    <= 1'b0;
      st_r     <= ST_OK;
    end
    if (cmd.st_we) begin
      st_r <= cmd.st;
    end
    if (cmd.ld_a) begin
      ar_r <= mem_q_r[63:32];
      ai_r <= mem_q_r[31:0];
    end
    if (cmd.ld_b) begin
      br_r <= mem_q_r[63:32];
      bi_r <= mem_q_r[31:0];
    end
    if (cmd.mul_en) begin
      prod_r <= op_x * op_y;
    end
    case (cmd.acc_op)
      ACC_LOAD: acc_r <= 66'(prod_r);
      ACC_ADD:  acc_r <= acc_r + 66'(prod_r);
      ACC_SUB:  acc_r <= acc_r - 66'(prod_r);
      default:  acc_r <= acc_r;
    endcase
    case (cmd.den_op)
      ACC_LOAD: den_r <= prod_r;
      ACC_ADD:  den_r <= den_r + prod_r;
      default:  den_r <= den_r;
    endcase
    if (cmd.div_start) begin
      div_neg_r <= acc_neg;
    end
    case (cmd.res_op)
      RES_IN: begin
        res_re_r <= in_r.real_in;
        res_im_r <= in_r.imag_in;
      end
      RES_MEM: begin
        res_re_r <= mem_q_r[63:32];
        res_im_r <= mem_q_r[31:0];
      end
      RES_ADD: begin
        res_re_r <= add_c[31:0];
        res_im_r <= mim_c[31:0];
        sat_r    <= sat_r | add_c[32] | mim_c[32];
      end
      RES_SUB: begin
        res_re_r <= sub_c[31:0];
        res_im_r <= sim_c[31:0];
        sat_r    <= sat_r | sub_c[32] | sim_c[32];
      end
      RES_MUL_RE: begin
        res_re_r <= mre_c[31:0];
        sat_r    <= sat_r | mre_c[32];
      end
      RES_MUL_IM: begin
        res_im_r <= mre_c[31:0];
        sat_r    <= sat_r | mre_c[32];
      end
      RES_DIV_RE: begin
        res_re_r <= dv_c[31:0];
        sat_r    <= sat_r | dv_c[32];
      end
      RES_DIV_IM: begin
        res_im_r <= dv_c[31:0];
        sat_r    <= sat_r | dv_c[32];
      end
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      out_r.result_real <= res_re_r;
      out_r.result_imag <= res_im_r;
      out_r.status      <= sat_r ? ST_SAT : st_r;
      out_r.stack_depth <= depth_ext[6:0];
    end
  end

  assign depth_ext = {7'd0, cnt_r};

  assign sts.cnt_zero = cnt_r == '0;
  assign sts.cnt_one  = cnt_r == CW'(1);
  assign sts.cnt_lt2  = cnt_r < CW'(2);
  assign sts.full     = cnt_r >= CW'(STACK_DEPTH);
  assign sts.b_zero   = (br_r == 32'sd0) && (bi_r == 32'sd0);
  assign sts.div_busy = div_busy;
  assign out_data     = out_r;

endmodule

`default_nettype wire

// ----- rtl/csalu_ctrl.sv -----
// ----------------------------------------------------------------------------
// csalu_ctrl
// Sequencer: decodes the mode of each item and steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module csalu_ctrl import csalu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_mode,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire csalu_sts_t sts,
  output csalu_cmd_t      cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_POPW = 5'd2;
  localparam logic [4:0] S_RDB  = 5'd3;
  localparam logic [4:0] S_LDB  = 5'd4;
  localparam logic [4:0] S_EXEC = 5'd5;
  localparam logic [4:0] S_M1   = 5'd6;
  localparam logic [4:0] S_M2   = 5'd7;
  localparam logic [4:0] S_M3   = 5'd8;
  localparam logic [4:0] S_M4   = 5'd9;
  localparam logic [4:0] S_M5   = 5'd10;
  localparam logic [4:0] S_D1   = 5'd11;
  localparam logic [4:0] S_D2   = 5'd12;
  localparam logic [4:0] S_D3   = 5'd13;
  localparam logic [4:0] S_D4   = 5'd14;
  localparam logic [4:0] S_D5   = 5'd15;
  localparam logic [4:0] S_D6   = 5'd16;
  localparam logic [4:0] S_DW1  = 5'd17;
  localparam logic [4:0] S_DW2  = 5'd18;
  localparam logic [4:0] S_FIN  = 5'd19;

  logic [4:0] state_r, state_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          mode_nxt  = in_mode;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_FIN;
        if (mode_r == MODE_PUSH) begin
          if (sts.full) begin
            cmd.st_we = 1'b1;
            cmd.st    = ST_OVER;
          end else begin
            cmd.wr_en   = 1'b1;
            cmd.cnt_inc = 1'b1;
            cmd.res_op  = RES_IN;
          end
        end else if (mode_r == MODE_POP) begin
          if (sts.cnt_zero) begin
            cmd.st_we = 1'b1;
            cmd.st    = ST_UNDER;
          end else begin
            cmd.cnt_dec = 1'b1;
            if (!sts.cnt_one) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sec = 1'b1;
              state_nxt  = S_POPW;
            end
          end
        end else if (mode_r inside {MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV}) begin
          if (sts.cnt_lt2) begin
            cmd.st_we = 1'b1;
            cmd.st    = ST_UNDER;
          end else begin
            cmd.rd_en = 1'b1;
            state_nxt = S_RDB;
          end
        end
      end
      S_POPW: begin
        cmd.res_op = RES_MEM;
        state_nxt  = S_FIN;
      end
      S_RDB: begin
        cmd.ld_a   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sec = 1'b1;
        state_nxt  = S_LDB;
      end
      S_LDB: begin
        cmd.ld_b  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        case (mode_r)
          MODE_ADD: cmd.res_op = RES_ADD;
          MODE_SUB: cmd.res_op = RES_SUB;
          MODE_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_AR_BR;
            state_nxt   = S_M1;
          end
          default: begin
            if (sts.b_zero) begin
              cmd.st_we = 1'b1;
              cmd.st    = ST_DIVZ;
            end else begin
              cmd.mul_en  = 1'b1;
              cmd.mul_sel = MUL_BR_BR;
              state_nxt   = S_D1;
            end
          end
        endcase
      end
      S_M1: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AI_BI;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.acc_op  = ACC_SUB;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AR_BI;
        state_nxt   = S_M3;
      end
      S_M3: begin
        cmd.res_op  = RES_MUL_RE;
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AI_BR;
        state_nxt   = S_M4;
      end
      S_M4: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = S_M5;
      end
      S_M5: begin
        cmd.res_op = RES_MUL_IM;
        state_nxt  = S_FIN;
      end
      S_D1: begin
        cmd.den_op  = ACC_LOAD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BI_BI;
        state_nxt   = S_D2;
      end
      S_D2: begin
        cmd.den_op  = ACC_ADD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AR_BR;
        state_nxt   = S_D3;
      end
      S_D3: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AI_BI;
        state_nxt   = S_D4;
      end
      S_D4: begin
        cmd.acc_op  = ACC_ADD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AI_BR;
        state_nxt   = S_D5;
      end
      S_D5: begin
        cmd.div_start = 1'b1;
        cmd.acc_op    = ACC_LOAD;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_AR_BI;
        state_nxt     = S_D6;
      end
      S_D6: begin
        cmd.acc_op = ACC_SUB;
        state_nxt  = S_DW1;
      end
      S_DW1: begin
        if (!sts.div_busy) begin
          cmd.res_op    = RES_DIV_RE;
          cmd.div_start = 1'b1;
          state_nxt     = S_DW2;
        end
      end
      S_DW2: begin
        if (!sts.div_busy) begin
          cmd.res_op = RES_DIV_IM;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r <= mode_nxt;
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/complex_stack_alu_unit.sv -----
// ----------------------------------------------------------------------------
// complex_stack_alu_unit
// Stack of Q16.16 complex numbers with push, pop and complex arithmetic.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready   | in_item_t
//   out     | output    | out_valid / out_ready | out_item_t
//
// one item at a time; a divide is set by two 32-step passes of the
// restoring divider; a zero divisor ends before either pass,
// and a quotient too large skips its pass
// rst_n clears the state and the entry count; stack contents need no clear
// a result waits in the output register while the next item is taken
// ----------------------------------------------------------------------------
`default_nettype none

module complex_stack_alu_unit import csalu_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  csalu_cmd_t cmd;
  csalu_sts_t sts;

  csalu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_data.mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  csalu_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives push, pop, complex arithmetic and unused-mode items into the stack
// calculator with bursty input and a stalling receiver, predicts each result
// and compares it field by field in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import csalu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  complex_stack_alu_unit #(.STACK_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        errors;
  bit        stimulus_done;

  logic signed [31:0] model_re[DEPTH];
  logic signed [31:0] model_im[DEPTH];
  int                 model_count;
  int                 gen_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp_sum(input logic signed [63:0] s,
                                                   inout bit sat);
    if (s > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (s < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_mag(input logic [63:0] u,
                                                   input bit do_div,
                                                   input logic [63:0] den,
                                                   inout bit sat);
    bit          neg;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] r;
    if (u == 64'h8000000000000000) begin
      neg = 1'b0;
      mag = u;
    end else if (u[63]) begin
      neg = 1'b1;
      mag = ~u + 64'd1;
    end else begin
      neg = 1'b0;
      mag = u;
    end
    if (do_div) begin
      q = mag / den;
      r = mag % den;
      if (q >= 64'h10000) begin
        q = 64'h100000000;
      end else begin
        for (int i = 0; i < 16; i++) begin
          r = r << 1;
          q = q << 1;
          if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
          end
        end
      end
    end else begin
      q = mag >> 16;
    end
    if (!neg) begin
      if (q > 64'h7fffffff) begin
        sat = 1'b1;
        return 32'sh7fffffff;
      end
      return q[31:0];
    end
    if (q >= 64'h80000000) begin
      if (q > 64'h80000000) sat = 1'b1;
      return 32'sh80000000;
    end
    return -$signed(q[31:0]);
  endfunction

  function automatic out_item_t calc_result(input in_item_t it);
    out_item_t          res;
    bit                 sat;
    logic signed [31:0] ar, ai, br, bi;
    logic signed [63:0] p1, p2, p3, p4, den;
    res = '0;
    sat = 1'b0;
    res.status = ST_OK;
    if (it.mode == MODE_PUSH) begin
      if (model_count >= DEPTH) begin
        res.status = ST_OVER;
      end else begin
        res.result_real = it.real_in;
        res.result_imag = it.imag_in;
        model_re[model_count] = it.real_in;
        model_im[model_count] = it.imag_in;
        model_count++;
      end
    end else if (it.mode == MODE_POP) begin
      if (model_count == 0) begin
        res.status = ST_UNDER;
      end else begin
        model_count--;
        if (model_count > 0) begin
          res.result_real = model_re[model_count-1];
          res.result_imag = model_im[model_count-1];
        end
      end
    end else if (it.mode <= MODE_DIV) begin
      if (model_count < 2) begin
        res.status = ST_UNDER;
      end else begin
        ar = model_re[model_count-1];
        ai = model_im[model_count-1];
        br = model_re[model_count-2];
        bi = model_im[model_count-2];
        if (it.mode == MODE_ADD) begin
          res.result_real = clamp_sum(64'(ar) + 64'(br), sat);
          res.result_imag = clamp_sum(64'(ai) + 64'(bi), sat);
        end else if (it.mode == MODE_SUB) begin
          res.result_real = clamp_sum(64'(ar) - 64'(br), sat);
          res.result_imag = clamp_sum(64'(ai) - 64'(bi), sat);
        end else if (it.mode == MODE_MUL) begin
          p1 = 64'(ar) * 64'(br);
          p2 = 64'(ai) * 64'(bi);
          p3 = 64'(ar) * 64'(bi);
          p4 = 64'(ai) * 64'(br);
          res.result_real = clamp_mag(p1 - p2, 1'b0, 64'd1, sat);
          res.result_imag = clamp_mag(p3 + p4, 1'b0, 64'd1, sat);
        end else if (br == 0 && bi == 0) begin
          res.status = ST_DIVZ;
        end else begin
          p1 = 64'(ar) * 64'(br);
          p2 = 64'(ai) * 64'(bi);
          p3 = 64'(ar) * 64'(bi);
          p4 = 64'(ai) * 64'(br);
          den = 64'(br) * 64'(br) + 64'(bi) * 64'(bi);
          res.result_real = clamp_mag(p1 + p2, 1'b1, den, sat);
          res.result_imag = clamp_mag(p4 - p3, 1'b1, den, sat);
        end
        if (sat) res.status = ST_SAT;
      end
    end
    res.stack_depth = 7'(model_count);
    return res;
  endfunction

  // generator tracks depth so that pops and arithmetic are mostly legal
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      4: return $signed($urandom_range(0, 32'h7ff)) - 32'sh400;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_item(input logic [2:0] m, input logic signed [31:0] re,
                          input logic signed [31:0] im);
    in_item_t it;
    it.mode = m;
    it.real_in = re;
    it.imag_in = im;
    pending_items.push_back(it);
    if (m == MODE_PUSH && gen_count < DEPTH) gen_count++;
    else if (m == MODE_POP && gen_count > 0) gen_count--;
  endtask

  task automatic report_mismatch(input string what, input out_item_t got,
                                 input out_item_t want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  initial begin
    logic [2:0] m;
    int         r;
    errors = 0;
    stimulus_done = 1'b0;
    model_count = 0;
    gen_count = 0;
    rst_n = 1'b0;
    add_item(MODE_POP, 32'sd5, 32'sd6);
    add_item(MODE_ADD, 0, 0);
    add_item(MODE_PUSH, 32'sh7fffffff, 32'sh80000000);
    add_item(MODE_DIV, 0, 0);
    add_item(MODE_PUSH, 32'sh7fffffff, 32'sh80000000);
    add_item(MODE_ADD, 0, 0);
    add_item(MODE_SUB, 0, 0);
    add_item(MODE_MUL, 0, 0);
    add_item(MODE_DIV, 0, 0);
    add_item(MODE_PUSH, 0, 0);
    add_item(MODE_DIV, 0, 0);
    add_item(MODE_PUSH, 32'sh00010000, 32'sh00020000);
    add_item(MODE_MUL, 0, 0);
    add_item(3'd6, 32'sd1, 32'sd1);
    add_item(3'd7, 32'sd1, 32'sd1);
    add_item(MODE_POP, 0, 0);
    add_item(MODE_POP, 0, 0);
    add_item(MODE_POP, 0, 0);
    add_item(MODE_POP, 0, 0);
    for (int i = 0; i < 66; i++) add_item(MODE_PUSH, pick_value(), pick_value());
    add_item(MODE_DIV, 0, 0);
    for (int i = 0; i < 66; i++) add_item(MODE_POP, 0, 0);
    for (int i = 0; i < 1650; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) m = 3'($urandom_range(6, 7));
      else if (gen_count < 2 || r < 30) m = MODE_PUSH;
      else if (r < 45) m = MODE_POP;
      else m = 3'($urandom_range(MODE_ADD, MODE_DIV));
      if ($urandom_range(0, 9) == 0) m = 3'($urandom_range(0, 5));
      add_item(m, pick_value(), pick_value());
      if ($urandom_range(0, 199) == 0) begin
        while (gen_count < DEPTH) add_item(MODE_PUSH, pick_value(), pick_value());
        add_item(MODE_PUSH, pick_value(), pick_value());
      end
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0);
    stimulus_done = 1'b1;
  end

  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (in_valid && !in_ready) begin
    end else begin
      if (in_valid) begin
        expected_results.push_back(calc_result(in_data));
        void'(pending_items.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_items[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          if ($urandom_range(0, 2) != 0) gap_left <= $urandom_range(0, 60);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  int stall_phase;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected", out_data, '0);
        end else begin
          if (out_data.result_real !== expected_results[0].result_real)
            report_mismatch("result_real", out_data, expected_results[0]);
          if (out_data.result_imag !== expected_results[0].result_imag)
            report_mismatch("result_imag", out_data, expected_results[0]);
          if (out_data.status !== expected_results[0].status)
            report_mismatch("status", out_data, expected_results[0]);
          if (out_data.stack_depth !== expected_results[0].stack_depth)
            report_mismatch("stack_depth", out_data, expected_results[0]);
          void'(expected_results.pop_front());
        end
      end
      stall_phase <= (stall_phase + 1) % 400;
      if (stall_phase < 150) out_ready <= 1'b1;
      else if (stall_phase < 300) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 4) == 0);
    end
  end

  initial begin
    wait (stimulus_done);
    @(posedge clk);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
